FILE: rtl/core/gas_pkg.sv
// Package for the greedy activity selector: sizes, entry type, control structs and states.
package gas_pkg;

  // Capacity of the activity store and width of the time fields
  localparam int unsigned MAX_ACT   = 32;
  localparam int unsigned TIME_BITS = 16;
  // Width of the activity number field on the result channel
  localparam int unsigned NUM_W     = 6;
  // Fill count must hold MAX_ACT itself
  localparam int unsigned CNT_W     = $clog2(MAX_ACT + 1);

  // One stored activity
  typedef struct packed {
    logic [TIME_BITS-1:0] st;
    logic [TIME_BITS-1:0] ft;
    logic [NUM_W-1:0]     num;
  } gas_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // accept an input item
    logic start;      // the accepted item closes the set
    logic step;       // examine the head entry and shift the list
    logic push;       // move the pending result to the output register
    logic push_last;  // move the pending result out as the final one
  } gas_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;   // no entries left to examine
    logic take;       // head entry is selected
    logic pend_valid; // a selected result waits in the pending register
    logic out_free;   // output register can take a result this cycle
  } gas_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } gas_state_e;

endpackage

FILE: rtl/core/gas_ctrl.sv
// Controller of the greedy activity selector: load, scan and drain sequencing.
module gas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_activity_i,
  input  gas_pkg::gas_sts_t sts_i,
  output logic              in_stall_o,
  output gas_pkg::gas_cmd_t cmd_o
);

  gas_pkg::gas_state_e state_q, state_d;
  logic                head_blocked;

  // A selected head needs the pending slot; the slot needs the output register
  assign head_blocked = sts_i.take && sts_i.pend_valid && !sts_i.out_free;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gas_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gas_pkg::ST_IDLE: begin
        if (in_valid_i && last_activity_i) state_d = gas_pkg::ST_SCAN;
      end
      gas_pkg::ST_SCAN: begin
        if (sts_i.cnt_zero) state_d = gas_pkg::ST_DRAIN;
      end
      gas_pkg::ST_DRAIN: begin
        if (sts_i.out_free) state_d = gas_pkg::ST_IDLE;
      end
      default: state_d = gas_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      gas_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
        cmd_o.start = in_valid_i && last_activity_i;
      end
      gas_pkg::ST_SCAN: begin
        if (!sts_i.cnt_zero && !head_blocked) begin
          cmd_o.step = 1'b1;
          cmd_o.push = sts_i.take && sts_i.pend_valid;
        end
      end
      gas_pkg::ST_DRAIN: begin
        cmd_o.push_last = sts_i.out_free;
      end
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/core/gas_dp.sv
// Datapath of the greedy activity selector: sorted activity list, selection and output register.
module gas_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gas_pkg::TIME_BITS-1:0] start_time_i,
  input  logic [gas_pkg::TIME_BITS-1:0] finish_time_i,
  input  logic                          out_stall_i,
  input  gas_pkg::gas_cmd_t             cmd_i,
  output gas_pkg::gas_sts_t             sts_o,
  output logic                          out_valid_o,
  output logic [gas_pkg::NUM_W-1:0]     activity_number_o,
  output logic                          last_selected_o,
  output logic                          overflow_o
);

  localparam int unsigned MaxAct = gas_pkg::MAX_ACT;
  localparam int unsigned CntW   = gas_pkg::CNT_W;

  gas_pkg::gas_entry_t             list_q [MaxAct];
  gas_pkg::gas_entry_t             list_d [MaxAct];
  gas_pkg::gas_entry_t             new_entry;
  logic [MaxAct-1:0]               gt;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [CntW:0]                   cnt_inc;
  logic                            full;
  logic                            store;
  logic                            ovf_q;
  logic                            first_q;
  logic [gas_pkg::TIME_BITS-1:0]   ltf_q;
  logic                            take;
  logic                            pend_valid_q;
  logic [gas_pkg::NUM_W-1:0]       pend_num_q;
  logic                            out_valid_q;
  logic [gas_pkg::NUM_W-1:0]       out_num_q;
  logic                            out_last_q;
  logic                            out_ovf_q;
  logic                            out_free;

  assign full    = (cnt_q == CntW'(MaxAct));
  assign store   = cmd_i.load && !full;
  assign cnt_inc = {1'b0, cnt_q} + (CntW+1)'(1);

  assign new_entry.st  = start_time_i;
  assign new_entry.ft  = finish_time_i;
  assign new_entry.num = gas_pkg::NUM_W'(cnt_inc);

  // Entries past the fill count, or finishing later, move up to make room
  always_comb begin
    for (int i = 0; i < MaxAct; i++) begin
      gt[i] = (CntW'(i) >= cnt_q) || (list_q[i].ft > finish_time_i);
    end
  end

  // Stable insertion on load, shift toward the head on each scan step
  always_comb begin
    for (int i = 0; i < MaxAct; i++) list_d[i] = list_q[i];
    if (store) begin
      if (gt[0]) list_d[0] = new_entry;
      for (int i = 1; i < MaxAct; i++) begin
        if (gt[i-1]) begin
          list_d[i] = list_q[i-1];
        end else if (gt[i]) begin
          list_d[i] = new_entry;
        end
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < MaxAct - 1; i++) list_d[i] = list_q[i+1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxAct; i++) list_q[i] <= list_d[i];
  end

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (store) begin
      cnt_d = cnt_inc[CntW-1:0];
    end else if (cmd_i.step) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Head selection: first entry always, then start at or after last finish
  assign take     = first_q || (list_q[0].st >= ltf_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Control registers of the selection pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      first_q      <= 1'b0;
      ltf_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load && full) begin
        ovf_q <= 1'b1;
      end else if (cmd_i.push_last) begin
        ovf_q <= 1'b0;
      end
      if (cmd_i.start) begin
        first_q <= 1'b1;
      end else if (cmd_i.step) begin
        first_q <= 1'b0;
      end
      if (cmd_i.step && take) begin
        ltf_q        <= list_q[0].ft;
        pend_valid_q <= 1'b1;
      end else if (cmd_i.push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.push || cmd_i.push_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && take) pend_num_q <= list_q[0].num;
    if (cmd_i.push || cmd_i.push_last) begin
      out_num_q  <= pend_num_q;
      out_last_q <= cmd_i.push_last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.take       = take;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o       = out_valid_q;
  assign activity_number_o = out_num_q;
  assign last_selected_o   = out_last_q;
  assign overflow_o        = out_ovf_q;

endmodule

FILE: rtl/core/greedy_activity_selector_top.sv
// Top level of the greedy activity selector.
//
// Input channel: one activity per item (start_time_i, finish_time_i,
// last_activity_i), numbered 1 upward in arrival order. An item is taken
// when in_valid_i is high and in_stall_o is low. Each item is inserted in
// finish order into a list of up to MAX_ACT entries; items beyond
// capacity are dropped and mark the run's results with overflow_o.
// The item with last_activity_i closes the set and starts a selection pass
// that shifts the list from its head, one entry per cycle when not paused.
// Result channel: one item per selected activity, taken when out_valid_o is
// high and out_stall_i is low; last_selected_o marks the final one.
// Sequencing: the input is stalled from the closing item until the scan and
// the drain have finished. A selected activity waits in the pending register
// and moves to the output register when the next one is selected; the drain
// moves the final one out.
// A stalled receiver holds the output register; the scan pauses only when
// a new selection finds both the pending and the output register full.
// Reset empties the list and clears all valid flags; no clearing pass.
module greedy_activity_selector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gas_pkg::TIME_BITS-1:0] start_time_i,
  input  logic [gas_pkg::TIME_BITS-1:0] finish_time_i,
  input  logic                          last_activity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gas_pkg::NUM_W-1:0]     activity_number_o,
  output logic                          last_selected_o,
  output logic                          overflow_o
);

  gas_pkg::gas_cmd_t cmd;
  gas_pkg::gas_sts_t sts;

  gas_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .last_activity_i(last_activity_i),
    .sts_i          (sts),
    .in_stall_o     (in_stall_o),
    .cmd_o          (cmd)
  );

  gas_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_time_i     (start_time_i),
    .finish_time_i    (finish_time_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .activity_number_o(activity_number_o),
    .last_selected_o  (last_selected_o),
    .overflow_o       (overflow_o)
  );

  // A result is never written over one the receiver has not taken
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push || cmd.push_last) |-> sts.out_free)
    else $error("result pushed into a busy output register");

  // The drain only moves out a result that exists
  a_drain_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_last |-> sts.pend_valid)
    else $error("drain without a pending result");

  // The scan never steps past the end of the list
  a_step_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !sts.cnt_zero)
    else $error("scan step on an empty list");

  // The drain shows the final result in the next cycle
  a_drain_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_last |=> (out_valid_o && last_selected_o))
    else $error("final result not marked");

endmodule

FILE: bench/gas_checker.sv
// Checker for the greedy activity selector: watches both channels, predicts picks, compares.
module gas_checker
  import gas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [TIME_BITS-1:0] start_time_i,
  input  logic [TIME_BITS-1:0] finish_time_i,
  input  logic                 last_activity_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [NUM_W-1:0]     activity_number_i,
  input  logic                 last_selected_i,
  input  logic                 overflow_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected pick on the result channel
  typedef struct {
    logic [NUM_W-1:0] num;
    logic             last;
    logic             ovf;
  } pick_t;

  gas_entry_t           act_list[MAX_ACT];
  int unsigned          held_count;
  logic                 dropped;
  logic [TIME_BITS-1:0] prev_finish;
  pick_t                picks_q[$];
  int unsigned          fails;

  assign fail_count_o = fails;
  assign pending_o    = picks_q.size();

  // Stable sort by finish time, then the greedy pass; queues the picks
  function automatic void select_activities();
    gas_entry_t held;
    int         k;
    logic       taken[MAX_ACT];
    int         final_idx;
    pick_t      p;
    for (int i = 1; i < held_count; i++) begin
      held = act_list[i];
      k = i;
      while (k > 0 && act_list[k-1].ft > held.ft) begin
        act_list[k] = act_list[k-1];
        k--;
      end
      act_list[k] = held;
    end
    final_idx = 0;
    for (int j = 0; j < held_count; j++) begin
      taken[j] = (j == 0) || (act_list[j].st >= prev_finish);
      if (taken[j]) begin
        prev_finish = act_list[j].ft;
        final_idx = j;
      end
    end
    for (int j = 0; j < held_count; j++) begin
      if (taken[j]) begin
        p.num  = act_list[j].num;
        p.last = (j == final_idx);
        p.ovf  = dropped;
        picks_q.push_back(p);
      end
    end
    held_count = 0;
    dropped    = 1'b0;
  endfunction

  // Store an accepted activity; the one marked last closes the set
  function automatic void load_activity(logic [TIME_BITS-1:0] st, logic [TIME_BITS-1:0] ft,
                                        logic fin);
    if (held_count < MAX_ACT) begin
      act_list[held_count].st  = st;
      act_list[held_count].ft  = ft;
      act_list[held_count].num = NUM_W'(held_count + 1);
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (fin && held_count != 0) select_activities();
  endfunction

  // Compare one accepted result with the oldest expected pick
  function automatic void check_pick();
    pick_t p;
    if (picks_q.size() == 0) begin
      $error("unexpected result: activity_number %0d", activity_number_i);
      fails++;
      return;
    end
    p = picks_q.pop_front();
    if (activity_number_i !== p.num) begin
      $error("activity_number: expected %0d, got %0d", p.num, activity_number_i);
      fails++;
    end
    if (last_selected_i !== p.last) begin
      $error("last_selected: expected %0b, got %0b", p.last, last_selected_i);
      fails++;
    end
    if (overflow_i !== p.ovf) begin
      $error("overflow: expected %0b, got %0b", p.ovf, overflow_i);
      fails++;
    end
  endfunction

  // Sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count  = 0;
      dropped     = 1'b0;
      prev_finish = '0;
      picks_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_pick();
      if (in_valid_i && !in_stall_i) load_activity(start_time_i, finish_time_i, last_activity_i);
    end
  end

  initial fails = 0;

endmodule

FILE: bench/tb_greedy_activity_selector_top.sv
// Testbench top for the greedy activity selector: clock, reset, stimulus and verdict.
module tb_greedy_activity_selector_top;
  import gas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TARGET_ITEMS = 420;

  // Time patterns used for a set of activities
  typedef enum int {
    TM_NARROW,
    TM_FULL,
    TM_CHAIN,
    TM_MIXED
  } time_mode_e;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [TIME_BITS-1:0] start_time_i    = '0;
  logic [TIME_BITS-1:0] finish_time_i   = '0;
  logic                 last_activity_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [NUM_W-1:0]     activity_number_o;
  logic                 last_selected_o;
  logic                 overflow_o;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          sent_count      = 0;
  logic                 calm            = 1'b0;
  logic [TIME_BITS-1:0] chain_cursor    = '0;

  greedy_activity_selector_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .start_time_i      (start_time_i),
    .finish_time_i     (finish_time_i),
    .last_activity_i   (last_activity_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .activity_number_o (activity_number_o),
    .last_selected_o   (last_selected_o),
    .overflow_o        (overflow_o)
  );

  gas_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .start_time_i      (start_time_i),
    .finish_time_i     (finish_time_i),
    .last_activity_i   (last_activity_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .activity_number_i (activity_number_o),
    .last_selected_i   (last_selected_o),
    .overflow_i        (overflow_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls about 30% of cycles, except in the calm window
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 30);
  end

  // Present one item, hold it until accepted, then maybe pause with in_valid_i low
  // (a random pause after about one item in six: near 30% idle overall)
  task automatic send_activity(input logic [TIME_BITS-1:0] st, input logic [TIME_BITS-1:0] ft,
                               input logic fin);
    logic quiet;
    in_valid_i      <= 1'b1;
    start_time_i    <= st;
    finish_time_i   <= ft;
    last_activity_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
    quiet = (sent_count >= 150) && (sent_count < 260);
    calm <= quiet;
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Send a set of n activities with times drawn by the given pattern
  task automatic send_set(input int unsigned n, input time_mode_e mode);
    logic [TIME_BITS-1:0] st;
    logic [TIME_BITS-1:0] ft;
    time_mode_e           pick;
    chain_cursor = TIME_BITS'($urandom_range(65535));
    for (int unsigned i = 0; i < n; i++) begin
      pick = mode;
      if (mode == TM_MIXED) pick = time_mode_e'($urandom_range(0, 2));
      case (pick)
        TM_NARROW: begin
          st = TIME_BITS'($urandom_range(15));
          ft = TIME_BITS'($urandom_range(15));
        end
        TM_CHAIN: begin
          // mostly touching or slightly overlapping intervals
          st = chain_cursor - TIME_BITS'($urandom_range(0, 3));
          ft = st + TIME_BITS'($urandom_range(0, 8));
          chain_cursor = ft;
        end
        default: begin
          st = TIME_BITS'($urandom_range(65535));
          ft = TIME_BITS'($urandom_range(65535));
        end
      endcase
      send_activity(st, ft, i == n - 1);
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned r;
    int unsigned n;
    int unsigned set_idx;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single activity at both extremes
    send_activity('0, '0, 1'b1);
    send_activity('1, '1, 1'b1);
    // equal finishes keep arrival order; a start equal to the last finish is taken
    send_activity(16'd5, 16'd10, 1'b0);
    send_activity(16'd0, 16'd10, 1'b0);
    send_activity(16'd10, 16'd10, 1'b1);
    // unsorted arrival, a start after its own finish, full-range times
    send_activity(16'hFFFF, 16'h0000, 1'b0);
    send_activity(16'd100, 16'd200, 1'b0);
    send_activity(16'h0000, 16'hFFFF, 1'b0);
    send_activity(16'd200, 16'd300, 1'b1);
    // everything overlaps the earliest finisher
    send_activity(16'd0, 16'd100, 1'b0);
    send_activity(16'd1, 16'd100, 1'b0);
    send_activity(16'd2, 16'd50, 1'b1);
    // touching chain with zero-length activities
    send_activity(16'd0, 16'd5, 1'b0);
    send_activity(16'd5, 16'd9, 1'b0);
    send_activity(16'd9, 16'd9, 1'b0);
    send_activity(16'd9, 16'd20, 1'b0);
    send_activity(16'h5555, 16'hAAAA, 1'b1);

    // random sets: a full store, then an overflowing one, then mixed sizes
    set_idx = 0;
    while (sent_count < TARGET_ITEMS) begin
      r = $urandom_range(99);
      if (set_idx == 0) n = MAX_ACT;
      else if (set_idx == 1) n = MAX_ACT + 3;
      else if (r < 70) n = $urandom_range(1, 6);
      else if (r < 85) n = $urandom_range(7, 16);
      else if (r < 93) n = $urandom_range(MAX_ACT - 2, MAX_ACT);
      else n = $urandom_range(MAX_ACT + 1, MAX_ACT + 6);
      send_set(n, time_mode_e'($urandom_range(0, 3)));
      set_idx++;
    end
    in_valid_i <= 1'b0;
    calm <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS greedy_activity_selector_top");
    end else begin
      $display("FAIL greedy_activity_selector_top");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAIL greedy_activity_selector_top");
    $finish;
  end

endmodule

FILE: greedy_activity_selector_top.f
rtl/core/gas_pkg.sv
rtl/core/gas_ctrl.sv
rtl/core/gas_dp.sv
rtl/core/greedy_activity_selector_top.sv
bench/gas_checker.sv
bench/tb_greedy_activity_selector_top.sv
